/* design/fbcm_pkg.sv */
// Shared types and constants for the block chain manager.
// Used by fbcm_ctrl, fbcm_datapath and fat_block_chain_manager_core.
`timescale 1ns / 1ps
package fbcm_pkg;

  localparam int NUM_BLOCKS_DEF = 1024;
  localparam int NUM_FILES_DEF  = 16;

  localparam int OP_W     = 3;
  localparam int FILE_W   = 4;
  localparam int LB_W     = 10;
  localparam int STATUS_W = 3;
  localparam int BLOCK_W  = 10;
  localparam int FID_W    = 4;
  localparam int FREE_W   = 11;
  localparam int OPENS_W  = 8;

  localparam logic [OP_W-1:0] OP_CREATE    = 3'd0;
  localparam logic [OP_W-1:0] OP_TRANSLATE = 3'd1;
  localparam logic [OP_W-1:0] OP_APPEND    = 3'd2;
  localparam logic [OP_W-1:0] OP_OPEN      = 3'd3;
  localparam logic [OP_W-1:0] OP_CLOSE     = 3'd4;
  localparam logic [OP_W-1:0] OP_RELEASE   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_AT_END  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BEYOND  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REFUSED = 3'd4;

  localparam logic [OPENS_W-1:0] OPENS_MAX = 8'd255;

  typedef struct packed {
    logic init_wr;
    logic latch;
    logic exec;
    logic walk_rd;
    logic walk_ld;
    logic walk_fin;
    logic app_link;
    logic app_rd;
    logic app_fin;
  } cmd_t;

  typedef struct packed {
    logic init_last;
    logic go_walk;
    logic go_app;
    logic walk_stop;
  } sts_t;

endpackage

/* design/fbcm_ctrl.sv */
// Sequencer for the block chain manager: clearing pass, operation steps.
// Depends on fbcm_pkg; drives fbcm_datapath through cmd_t, reads sts_t.
`timescale 1ns / 1ps
module fbcm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  fbcm_pkg::sts_t sts,
  output fbcm_pkg::cmd_t cmd,
  output logic          busy,
  output logic          out_valid
);
  import fbcm_pkg::*;

  typedef enum logic [8:0] {
    S_INIT  = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_EXEC  = 9'b000000100,
    S_WALK  = 9'b000001000,
    S_WLOAD = 9'b000010000,
    S_ALINK = 9'b000100000,
    S_ARD   = 9'b001000000,
    S_AFIN  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (sts.init_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.go_walk) begin
          state_nxt = S_WALK;
        end else if (sts.go_app) begin
          state_nxt = S_ALINK;
        end else begin
          cmd.exec  = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_WALK: begin
        if (sts.walk_stop) begin
          cmd.walk_fin = 1'b1;
          state_nxt    = S_OUT;
        end else begin
          cmd.walk_rd = 1'b1;
          state_nxt   = S_WLOAD;
        end
      end
      S_WLOAD: begin
        cmd.walk_ld = 1'b1;
        state_nxt   = S_WALK;
      end
      S_ALINK: begin
        cmd.app_link = 1'b1;
        state_nxt    = S_ARD;
      end
      S_ARD: begin
        cmd.app_rd = 1'b1;
        state_nxt  = S_AFIN;
      end
      S_AFIN: begin
        cmd.app_fin = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

endmodule

/* design/fbcm_datapath.sv */
// Link table memory, free list and directory registers with result registers.
// Depends on fbcm_pkg; steered by fbcm_ctrl through cmd_t.
`timescale 1ns / 1ps
module fbcm_datapath #(
  parameter int NUM_BLOCKS = fbcm_pkg::NUM_BLOCKS_DEF,
  parameter int NUM_FILES  = fbcm_pkg::NUM_FILES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  fbcm_pkg::cmd_t                  cmd,
  output fbcm_pkg::sts_t                  sts,
  input  logic [fbcm_pkg::OP_W-1:0]       in_op,
  input  logic [fbcm_pkg::FILE_W-1:0]     in_file,
  input  logic [fbcm_pkg::LB_W-1:0]       in_logical_block,
  output logic [fbcm_pkg::STATUS_W-1:0]   out_status,
  output logic [fbcm_pkg::BLOCK_W-1:0]    out_block,
  output logic [fbcm_pkg::FID_W-1:0]      out_file_id,
  output logic [fbcm_pkg::FREE_W-1:0]     out_free_count,
  output logic [fbcm_pkg::OPENS_W-1:0]    out_open_count
);
  import fbcm_pkg::*;

  localparam int BW = $clog2(NUM_BLOCKS + 1);
  localparam int AW = $clog2(NUM_BLOCKS);
  localparam int FW = (NUM_FILES > 1) ? $clog2(NUM_FILES) : 1;
  localparam logic [BW-1:0] END_MARK = BW'(NUM_BLOCKS);

  logic [BW-1:0] link_mem [NUM_BLOCKS];
  logic [BW-1:0] rd_r;

  logic [BW-1:0]      first_r  [NUM_FILES];
  logic [BW-1:0]      last_r   [NUM_FILES];
  logic [BW-1:0]      blocks_r [NUM_FILES];
  logic [OPENS_W-1:0] opens_r  [NUM_FILES];
  logic [NUM_FILES-1:0] used_r;

  logic [BW-1:0] head_r, tail_r, total_r;
  logic [AW-1:0] ic_r;

  logic [OP_W-1:0] op_r;
  logic [FW-1:0]   fi_r;
  logic            fvalid_r;
  logic [LB_W-1:0] lb_r, cnt_r;
  logic [BW-1:0]   ph_r;

  logic [STATUS_W-1:0] res_status_r;
  logic [BW-1:0]       res_block_r;
  logic [FW-1:0]       res_fid_r;
  logic [OPENS_W-1:0]  res_opens_r;

  logic          free_found;
  logic [FW-1:0] free_pick;
  logic          rel_ok, rel_splice;
  logic [BW:0]   rel_sum;
  logic [BW-1:0] cur_first, cur_last, cur_blocks;
  logic [OPENS_W-1:0] cur_opens;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [BW-1:0] mem_wd;

  assign cur_first  = first_r[fi_r];
  assign cur_last   = last_r[fi_r];
  assign cur_blocks = blocks_r[fi_r];
  assign cur_opens  = opens_r[fi_r];

  always_comb begin
    free_found = 1'b0;
    free_pick  = '0;
    for (int i = NUM_FILES - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_found = 1'b1;
        free_pick  = FW'(i);
      end
    end
  end

  assign rel_ok     = (cur_opens == '0);
  assign rel_splice = (cur_blocks != '0) && (cur_first < END_MARK);
  assign rel_sum    = {1'b0, total_r} + {1'b0, cur_blocks};

  assign sts.init_last = (ic_r == AW'(NUM_BLOCKS - 1));
  assign sts.go_walk   = (op_r == OP_TRANSLATE) && fvalid_r;
  assign sts.go_app    = (op_r == OP_APPEND) && fvalid_r && (head_r < END_MARK);
  assign sts.walk_stop = (cnt_r == lb_r) || (ph_r >= END_MARK);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    mem_re = 1'b0;
    mem_ra = '0;
    if (cmd.init_wr) begin
      mem_we = 1'b1;
      mem_wa = ic_r;
      mem_wd = BW'(ic_r) + 1'b1;
    end
    if (cmd.app_link) begin
      mem_we = (cur_first < END_MARK) && (cur_last < END_MARK);
      mem_wa = cur_last[AW-1:0];
      mem_wd = head_r;
    end
    if (cmd.app_fin) begin
      mem_we = 1'b1;
      mem_wa = head_r[AW-1:0];
      mem_wd = END_MARK;
    end
    if (cmd.exec && (op_r == OP_RELEASE) && fvalid_r && rel_ok && rel_splice &&
        (tail_r < END_MARK)) begin
      mem_we = 1'b1;
      mem_wa = tail_r[AW-1:0];
      mem_wd = cur_first;
    end
    if (cmd.walk_rd) begin
      mem_re = 1'b1;
      mem_ra = ph_r[AW-1:0];
    end
    if (cmd.app_rd) begin
      mem_re = 1'b1;
      mem_ra = head_r[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) link_mem[mem_wa] <= mem_wd;
    if (mem_re) rd_r <= link_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_FILES; i++) begin
        first_r[i]  <= END_MARK;
        last_r[i]   <= END_MARK;
        blocks_r[i] <= '0;
        opens_r[i]  <= '0;
      end
      used_r  <= '0;
      head_r  <= '0;
      tail_r  <= BW'(NUM_BLOCKS - 1);
      total_r <= END_MARK;
      ic_r    <= '0;
    end else begin
      if (cmd.init_wr) ic_r <= ic_r + 1'b1;

      if (cmd.latch) begin
        op_r     <= in_op;
        fi_r     <= FW'(in_file);
        fvalid_r <= (int'(in_file) < NUM_FILES);
        lb_r     <= in_logical_block;
        cnt_r    <= '0;
        ph_r     <= first_r[FW'(in_file)];
      end

      if (cmd.exec) begin
        res_block_r <= '0;
        res_fid_r   <= '0;
        res_opens_r <= '0;
        res_status_r <= ST_OK;
        if (op_r == OP_CREATE) begin
          if (free_found) begin
            used_r[free_pick]   <= 1'b1;
            first_r[free_pick]  <= END_MARK;
            last_r[free_pick]   <= END_MARK;
            blocks_r[free_pick] <= '0;
            res_fid_r           <= free_pick;
            res_opens_r         <= opens_r[free_pick];
          end else begin
            res_status_r <= ST_NOSPACE;
          end
        end else if ((op_r > OP_RELEASE) || !fvalid_r) begin
          res_status_r <= ST_REFUSED;
        end else begin
          unique case (op_r)
            OP_APPEND: begin
              res_status_r <= ST_NOSPACE;
              res_opens_r  <= cur_opens;
            end
            OP_OPEN: begin
              if (cur_opens != OPENS_MAX) begin
                opens_r[fi_r] <= cur_opens + 1'b1;
                res_opens_r   <= cur_opens + 1'b1;
              end else begin
                res_opens_r <= cur_opens;
              end
            end
            OP_CLOSE: begin
              if (cur_opens == '0) begin
                res_status_r <= ST_REFUSED;
                res_opens_r  <= cur_opens;
              end else begin
                opens_r[fi_r] <= cur_opens - 1'b1;
                res_opens_r   <= cur_opens - 1'b1;
              end
            end
            OP_RELEASE: begin
              res_opens_r <= cur_opens;
              if (!rel_ok) begin
                res_status_r <= ST_REFUSED;
              end else begin
                if (rel_splice) begin
                  if (tail_r >= END_MARK) head_r <= cur_first;
                  tail_r <= cur_last;
                  if (rel_sum > (BW + 1)'(NUM_BLOCKS)) begin
                    total_r <= END_MARK;
                  end else begin
                    total_r <= rel_sum[BW-1:0];
                  end
                end
                used_r[fi_r]   <= 1'b0;
                first_r[fi_r]  <= END_MARK;
                last_r[fi_r]   <= END_MARK;
                blocks_r[fi_r] <= '0;
              end
            end
            default: begin
              res_status_r <= ST_REFUSED;
            end
          endcase
        end
      end

      if (cmd.walk_ld) begin
        ph_r  <= rd_r;
        cnt_r <= cnt_r + 1'b1;
      end

      if (cmd.walk_fin) begin
        res_fid_r   <= '0;
        res_opens_r <= cur_opens;
        res_block_r <= '0;
        if (cnt_r != lb_r) begin
          res_status_r <= ST_BEYOND;
        end else if (ph_r >= END_MARK) begin
          res_status_r <= ST_AT_END;
        end else begin
          res_status_r <= ST_OK;
          res_block_r  <= ph_r;
        end
      end

      if (cmd.app_fin) begin
        if (cur_first >= END_MARK) first_r[fi_r] <= head_r;
        last_r[fi_r] <= head_r;
        if (rd_r >= END_MARK) begin
          head_r <= END_MARK;
          tail_r <= END_MARK;
        end else begin
          head_r <= rd_r;
        end
        if (cur_blocks < END_MARK) blocks_r[fi_r] <= cur_blocks + 1'b1;
        if (total_r != '0) total_r <= total_r - 1'b1;
        res_status_r <= ST_OK;
        res_block_r  <= head_r;
        res_fid_r    <= '0;
        res_opens_r  <= cur_opens;
      end
    end
  end

  assign out_status     = res_status_r;
  assign out_block      = BLOCK_W'(res_block_r);
  assign out_file_id    = FID_W'(res_fid_r);
  assign out_free_count = FREE_W'(total_r);
  assign out_open_count = res_opens_r;

endmodule

/* design/fat_block_chain_manager_core.sv */
// Top level of the block chain manager: sequencer plus datapath.
// Depends on fbcm_pkg, fbcm_ctrl and fbcm_datapath.
`timescale 1ns / 1ps
// After reset the block sweeps all NUM_BLOCKS entries of the link table,
// one entry per cycle, with busy high. An operation is taken when start is
// high and busy is low; its result shows for exactly one cycle with
// out_valid and cannot be held off, so the receiver must take it then.
// Create, open, close, release and refused operations pass through the
// latch, execute and output steps. Append adds link, read and finish steps
// unless the free list is empty. Translate reads links through the single
// read port, a read then a load step per link, up to in_logical_block links.
module fat_block_chain_manager_core #(
  parameter int NUM_BLOCKS = fbcm_pkg::NUM_BLOCKS_DEF,
  parameter int NUM_FILES  = fbcm_pkg::NUM_FILES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [fbcm_pkg::OP_W-1:0]       in_op,
  input  logic [fbcm_pkg::FILE_W-1:0]     in_file,
  input  logic [fbcm_pkg::LB_W-1:0]       in_logical_block,
  output logic                            out_valid,
  output logic [fbcm_pkg::STATUS_W-1:0]   out_status,
  output logic [fbcm_pkg::BLOCK_W-1:0]    out_block,
  output logic [fbcm_pkg::FID_W-1:0]      out_file_id,
  output logic [fbcm_pkg::FREE_W-1:0]     out_free_count,
  output logic [fbcm_pkg::OPENS_W-1:0]    out_open_count
);
  import fbcm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fbcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  fbcm_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .NUM_FILES  (NUM_FILES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_op            (in_op),
    .in_file          (in_file),
    .in_logical_block (in_logical_block),
    .out_status       (out_status),
    .out_block        (out_block),
    .out_file_id      (out_file_id),
    .out_free_count   (out_free_count),
    .out_open_count   (out_open_count)
  );

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy && !out_valid)
    else $error("transfer not followed by busy");

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_free_count) <= NUM_BLOCKS))
    else $error("free count above block count");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_AT_END ||
                   out_status == ST_BEYOND || out_status == ST_NOSPACE ||
                   out_status == ST_REFUSED))
    else $error("undefined status code");

endmodule
